### design/greedy_word_wrap_unit_assert.svh
`ifndef GREEDY_WORD_WRAP_UNIT_ASSERT_SVH
`define GREEDY_WORD_WRAP_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define GWW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("greedy_word_wrap_unit: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define GWW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("greedy_word_wrap_unit: next-cycle check failed");

`endif

### design/gww_pkg.sv
package gww_pkg;

    localparam int CODE_W   = 21;
    localparam int ADV_W    = 16;
    localparam int OFS_W    = 22;
    localparam int START_W  = 16;
    localparam int LEN_W    = 17;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int M_PAD_W  = M_DATA_W - START_W - LEN_W;
    localparam int S_PAD_W  = S_DATA_W - CODE_W - ADV_W;

    localparam logic [CODE_W-1:0] SPACE_CODE  = CODE_W'(32);
    localparam logic [OFS_W-1:0]  WRAP_RESET  = {OFS_W{1'b1}};

    typedef struct packed {
        logic [START_W-1:0] row_first;
        logic [LEN_W-1:0]   row_length;
        logic               run_end;
    } row_t;

endpackage

### design/greedy_word_wrap_unit.sv
// Channel   Dir  Content (tdata from bit 0 up)              Marker
// s_axis    in   code_point[20:0], advance[36:21], zeros    tlast = last_char
// m_axis    out  row_first[15:0], row_length[32:16], zeros  tlast = run_end
// cfg       in   cfg_wdata = wrap_width, taken when cfg_we  -
//
// One character is taken per cycle while s_axis_tready is high; its rows enter the result queue the cycle after.
// A character giving two rows writes both into the queue at once; they leave the result port one after the other.
// s_axis_tready holds high while the four-entry result queue has at least two free slots.
// Reset (aresetn low, synchronous) clears the text state and the queue and
// sets wrap_width to its maximum.
module greedy_word_wrap_unit
    import gww_pkg::*;
#(
    parameter int MAX_TEXT = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // code_point[20:0], advance[36:21], zero pad
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // row_first[15:0], row_length[32:16], zero pad
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [OFS_W-1:0]      cfg_wdata
);

    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam logic [PW-1:0] MAX_IDX = PW'(MAX_TEXT);

    logic [OFS_W-1:0] wrap_reg;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    rb_reg, rb_next;
    logic [PW-1:0]    ls_reg, ls_next;
    logic [OFS_W-1:0] ro_reg, ro_next;
    logic [OFS_W-1:0] wo_reg, wo_next;
    logic             lw_reg, lw_next;

    row_t       q_reg [4];
    logic [1:0] head_reg, tail_reg;
    logic [2:0] cnt_reg, cnt_next;

    logic [CODE_W-1:0] code;
    logic [ADV_W-1:0]  adv;
    logic              last, sp, acc, pop;
    logic [PW-1:0]     nxt, ls_v, nb;
    logic [OFS_W-1:0]  wo_v;
    logic [OFS_W:0]    sum, sum2;
    logic [1:0]        n;
    logic [PW-1:0]     e0s, e0e, e1s, e1e;
    row_t              r0, r1;

    function automatic logic [PW-1:0] inc_sat(input logic [PW-1:0] v);
        return (v < MAX_IDX) ? v + PW'(1) : MAX_IDX;
    endfunction

    function automatic row_t mk_row(input logic [PW-1:0] s, input logic [PW-1:0] e,
                                    input logic fin);
        row_t r;
        logic [PW-1:0] d;
        d = (e > s) ? e - s : '0;
        r.row_first  = START_W'(s);
        r.row_length = LEN_W'(d);
        r.run_end    = fin;
        return r;
    endfunction

    assign code = s_axis_tdata[CODE_W-1:0];
    assign adv  = s_axis_tdata[CODE_W +: ADV_W];
    assign last = s_axis_tlast;
    assign sp   = (code == SPACE_CODE);
    assign nxt  = inc_sat(pos_reg);
    assign ls_v = sp ? pos_reg : ls_reg;
    assign wo_v = sp ? '0 : wo_reg;
    assign nb   = inc_sat(ls_v);
    assign sum  = {1'b0, ro_reg} + {{(OFS_W-ADV_W+1){1'b0}}, adv};
    assign sum2 = {1'b0, wo_v} + {{(OFS_W-ADV_W+1){1'b0}}, adv};

    always_comb begin
        pos_next = pos_reg;
        rb_next  = rb_reg;
        ls_next  = ls_reg;
        ro_next  = ro_reg;
        wo_next  = wo_reg;
        lw_next  = lw_reg;
        n   = 2'd0;
        e0s = rb_reg;
        e0e = nxt;
        e1s = nb;
        e1e = nxt;
        if (lw_reg) begin
            if (!sp) begin
                if (last) begin
                    n = 2'd1;
                end
            end else begin
                n       = 2'd1;
                e0e     = pos_reg;
                lw_next = 1'b0;
                ro_next = '0;
                wo_next = '0;
                rb_next = nxt;
                ls_next = nxt;
            end
        end else if (sp && ro_reg == '0) begin
            rb_next = nxt;
            ls_next = nxt;
            wo_next = '0;
        end else begin
            if (sp) begin
                ls_next = pos_reg;
                wo_next = '0;
            end
            if (sum > {1'b0, wrap_reg}) begin
                if (ls_v == rb_reg) begin
                    if (sp) begin
                        n       = 2'd1;
                        e0e     = pos_reg;
                        rb_next = nxt;
                        ls_next = nxt;
                        ro_next = '0;
                        wo_next = '0;
                    end else begin
                        lw_next = 1'b1;
                        if (last) begin
                            n = 2'd1;
                        end
                    end
                end else begin
                    n       = 2'd1;
                    e0e     = ls_v;
                    rb_next = nb;
                    ls_next = nb;
                    if (sp) begin
                        ro_next = '0;
                        wo_next = '0;
                    end else begin
                        ro_next = wo_v;
                        if (sum2 > {1'b0, wrap_reg}) begin
                            lw_next = 1'b1;
                        end else begin
                            ro_next = OFS_W'(sum2);
                            wo_next = OFS_W'(sum2);
                        end
                        if (last) begin
                            n = 2'd2;
                        end
                    end
                end
            end else begin
                ro_next = OFS_W'(sum);
                if (!sp) begin
                    wo_next = OFS_W'(sum2);
                end
                if (last) begin
                    n = 2'd1;
                end
            end
        end
        if (last) begin
            pos_next = '0;
            rb_next  = '0;
            ls_next  = '0;
            ro_next  = '0;
            wo_next  = '0;
            lw_next  = 1'b0;
        end else begin
            pos_next = nxt;
        end
    end

    assign r0 = mk_row(e0s, e0e, (n == 2'd1));
    assign r1 = mk_row(e1s, e1e, 1'b1);

    assign s_axis_tready = (cnt_reg <= 3'd2);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign cnt_next      = cnt_reg + (acc ? {1'b0, n} : 3'd0) - {2'b0, pop};

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, q_reg[head_reg].row_length,
                           q_reg[head_reg].row_first};
    assign m_axis_tlast = q_reg[head_reg].run_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= WRAP_RESET;
            pos_reg  <= '0;
            rb_reg   <= '0;
            ls_reg   <= '0;
            ro_reg   <= '0;
            wo_reg   <= '0;
            lw_reg   <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cfg_we) begin
                wrap_reg <= cfg_wdata;
            end
            if (acc) begin
                pos_reg  <= pos_next;
                rb_reg   <= rb_next;
                ls_reg   <= ls_next;
                ro_reg   <= ro_next;
                wo_reg   <= wo_next;
                lw_reg   <= lw_next;
                tail_reg <= tail_reg + n;
            end
            if (pop) begin
                head_reg <= head_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && n != 2'd0) begin
            q_reg[tail_reg] <= r0;
        end
        if (acc && n == 2'd2) begin
            q_reg[tail_reg + 2'd1] <= r1;
        end
    end

endmodule

### design/gww_checker.sv
`include "greedy_word_wrap_unit_assert.svh"

module gww_checker
    import gww_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    logic m_stall;

    assign m_stall = m_axis_tvalid && !m_axis_tready;

    `GWW_ASSERT_NEXT(a_m_valid_held, aclk, aresetn, m_stall, m_axis_tvalid)
    `GWW_ASSERT_NEXT(a_m_data_held, aclk, aresetn, m_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `GWW_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[M_DATA_W-1:START_W+LEN_W] == '0)
    `GWW_ASSERT_NOW(a_ready_after_reset, aclk, aresetn, !$past(aresetn), s_axis_tready && !m_axis_tvalid)

endmodule

bind greedy_word_wrap_unit gww_checker u_gww_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
